@@ hw/rtl/modbus_rtu_slave_engine_defines.svh @@
// Assertion macros shared by the RTL of the Modbus RTU slave engine.
`ifndef MODBUS_RTU_SLAVE_ENGINE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_ENGINE_DEFINES_SVH

// Checked only while out of reset.
`define MRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mrs assertion failed");

// Checked on every edge, reset included.
`define MRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mrs assertion failed");

`endif

@@ hw/rtl/mrs_pkg.sv @@
// Types and constants of the Modbus RTU slave engine.
package mrs_pkg;

  localparam logic [2:0] OP_RX_BYTE  = 3'd0;
  localparam logic [2:0] OP_EOF      = 3'd1;
  localparam logic [2:0] OP_WR_HOLD  = 3'd2;
  localparam logic [2:0] OP_WR_INPUT = 3'd3;
  localparam logic [2:0] OP_RD_HOLD  = 3'd4;
  localparam logic [2:0] OP_RD_INPUT = 3'd5;

  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_LOCAL = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_RD_HOLD  = 3'd1;
  localparam logic [2:0] EV_WRITE    = 3'd2;
  localparam logic [2:0] EV_RD_INPUT = 3'd3;
  localparam logic [2:0] EV_SHORT    = 3'd4;
  localparam logic [2:0] EV_FOREIGN  = 3'd5;
  localparam logic [2:0] EV_BAD      = 3'd6;
  localparam logic [2:0] EV_RANGE    = 3'd7;

  localparam logic [7:0] FN_RD_HOLD  = 8'd3;
  localparam logic [7:0] FN_RD_INPUT = 8'd4;
  localparam logic [7:0] FN_WR_HOLD  = 8'd6;

  localparam logic [7:0]  BROADCAST_ID = 8'd247;
  localparam logic [7:0]  DEV_ID_RESET = 8'd100;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam int          WORD_W       = 16;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LREAD, ST_LEMIT, ST_DROP, ST_CHK, ST_DECIDE,
    ST_TX_HDR, ST_RD_REQ, ST_RD_WAIT, ST_TX_HI, ST_TX_LO, ST_CRCL, ST_CRCH
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] read_value;
    logic [2:0]  event_res;
    logic [6:0]  written_addr;
    logic [15:0] written_value;
    logic        last;
  } out_item_t;

endpackage

@@ hw/rtl/mrs_ram.sv @@
// Register file memory: one write port, one read port, registered read.
module mrs_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [mrs_pkg::WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [mrs_pkg::WORD_W-1:0] rdata_o
);
  import mrs_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hw/rtl/mrs_crc.sv @@
// CRC-16 accumulator, one byte per cycle while en_i is high.
module mrs_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        init_i,
  input  logic        en_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import mrs_pkg::*;

  logic [15:0] crc_q, crc_d;

  always_comb begin
    logic [15:0] c;
    c = crc_q ^ {8'h00, byte_i};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_d = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else if (init_i) begin
      crc_q <= CRC_INIT;
    end else if (en_i) begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

@@ hw/rtl/modbus_rtu_slave_engine.sv @@
// Modbus RTU slave engine top level: frame store, decoder, reply sequencer.
//
// Requests on the input channel either feed received bytes (the first eight
// are stored), close a frame, or access the holding and input register files
// locally. Both register files are synchronous memories of REG_COUNT words.
// After reset the block sweeps both memories to zero, one word per cycle, so
// in_ready_o stays low until the sweep is done; device_id writes are taken at
// any time. The block serves one request at a time; a local read waits on any
// output stall. An end of frame that passes the length, address and function
// checks runs the CRC over bytes 0..5 one byte per cycle, then decides. A
// write reply streams 8 bytes, one per cycle unless out_ready_i stalls. A read
// reply of N registers sends 3 header bytes, then per register a memory read,
// capture, high byte and low byte, then 2 CRC bytes, an order set by the
// single memory read port. The reply CRC is accumulated on the bytes as they
// are sent. One output register holds the outgoing result; a stall on
// out_ready_i simply holds the sequencer.
`include "modbus_rtu_slave_engine_defines.svh"

module modbus_rtu_slave_engine #(
  parameter int REG_COUNT = 128,
  parameter int MAX_READ  = 29
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] data_i,
  input  logic [6:0]  reg_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [15:0] read_value_o,
  output logic [2:0]  event_res_o,
  output logic [6:0]  written_addr_o,
  output logic [15:0] written_value_o,
  output logic        last_o
);
  import mrs_pkg::*;

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int CW = $clog2(MAX_READ + 1);
  localparam logic [16:0] RC17   = 17'(REG_COUNT);
  localparam logic [15:0] MR16   = 16'(MAX_READ);
  localparam logic [AW-1:0] CLR_LAST = AW'(REG_COUNT - 1);

  state_e          state_q, state_d;
  logic [7:0]      byte_cnt_q, byte_cnt_d;
  logic [7:0]      frame_q [8];
  logic            frame_we;
  logic [7:0]      dev_id_q;
  logic [6:0]      lw_addr_q, lw_addr_d;
  logic [15:0]     lw_val_q, lw_val_d;
  logic [2:0]      code_q, code_d;
  logic [2:0]      idx_q, idx_d;
  logic [2:0]      hdr_last_q, hdr_last_d;
  logic            is_rd_q, is_rd_d;
  logic            sel_in_q, sel_in_d;
  logic            lok_q, lok_d;
  logic [AW-1:0]   ptr_q, ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [15:0]     word_q, word_d;
  logic [AW-1:0]   clr_q, clr_d;
  out_item_t       out_q, item;
  logic            out_valid_q;
  logic            emit, slot_free, in_acc, idx_ok;

  logic            crc_init, crc_en;
  logic [7:0]      crc_byte;
  logic [15:0]     crc;

  logic            hold_we, inp_we;
  logic [AW-1:0]   hold_waddr, inp_waddr, rd_addr;
  logic [15:0]     hold_wdata, inp_wdata, hold_rdata, inp_rdata;

  logic [15:0]     fb_addr, fb_val;
  logic [16:0]     fb_end;
  logic [7:0]      hdr_byte;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign idx_ok      = 17'(reg_index_i) < RC17;
  assign fb_addr     = {frame_q[2], frame_q[3]};
  assign fb_val      = {frame_q[4], frame_q[5]};
  assign fb_end      = 17'(fb_addr) + 17'(fb_val);
  assign rd_addr     = (state_q == ST_IDLE) ? AW'(reg_index_i) : ptr_q;
  assign hdr_byte    = (is_rd_q && idx_q == 3'd2) ? 8'({cnt_q, 1'b0}) : frame_q[idx_q];

  mrs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .init_i (crc_init),
    .en_i   (crc_en),
    .byte_i (crc_byte),
    .crc_o  (crc)
  );

  mrs_ram #(.DEPTH(REG_COUNT), .AW(AW)) u_hold (
    .clk_i   (clk_i),
    .we_i    (hold_we),
    .waddr_i (hold_waddr),
    .wdata_i (hold_wdata),
    .raddr_i (rd_addr),
    .rdata_o (hold_rdata)
  );

  mrs_ram #(.DEPTH(REG_COUNT), .AW(AW)) u_inp (
    .clk_i   (clk_i),
    .we_i    (inp_we),
    .waddr_i (inp_waddr),
    .wdata_i (inp_wdata),
    .raddr_i (rd_addr),
    .rdata_o (inp_rdata)
  );

  always_comb begin
    state_d    = state_q;
    byte_cnt_d = byte_cnt_q;
    frame_we   = 1'b0;
    lw_addr_d  = lw_addr_q;
    lw_val_d   = lw_val_q;
    code_d     = code_q;
    idx_d      = idx_q;
    hdr_last_d = hdr_last_q;
    is_rd_d    = is_rd_q;
    sel_in_d   = sel_in_q;
    lok_d      = lok_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    word_d     = word_q;
    clr_d      = clr_q;
    crc_init   = 1'b0;
    crc_en     = 1'b0;
    crc_byte   = 8'h00;
    hold_we    = 1'b0;
    hold_waddr = AW'(reg_index_i);
    hold_wdata = data_i;
    inp_we     = 1'b0;
    inp_waddr  = AW'(reg_index_i);
    inp_wdata  = data_i;
    emit       = 1'b0;
    item       = '0;
    item.written_addr  = lw_addr_q;
    item.written_value = lw_val_q;

    unique case (state_q)
      ST_CLEAR: begin
        hold_we    = 1'b1;
        hold_waddr = clr_q;
        hold_wdata = '0;
        inp_we     = 1'b1;
        inp_waddr  = clr_q;
        inp_wdata  = '0;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (opcode_i)
            OP_RX_BYTE: begin
              frame_we = (byte_cnt_q < 8'd8);
              if (byte_cnt_q != 8'hFF) begin
                byte_cnt_d = byte_cnt_q + 8'd1;
              end
            end
            OP_EOF: begin
              byte_cnt_d = '0;
              if (byte_cnt_q < 8'd8) begin
                code_d  = EV_SHORT;
                state_d = ST_DROP;
              end else if (frame_q[0] != dev_id_q && frame_q[0] != BROADCAST_ID) begin
                code_d  = EV_FOREIGN;
                state_d = ST_DROP;
              end else if (frame_q[1] != FN_RD_HOLD && frame_q[1] != FN_RD_INPUT &&
                           frame_q[1] != FN_WR_HOLD) begin
                code_d  = EV_BAD;
                state_d = ST_DROP;
              end else begin
                crc_init = 1'b1;
                idx_d    = '0;
                state_d  = ST_CHK;
              end
            end
            OP_WR_HOLD:  hold_we = idx_ok;
            OP_WR_INPUT: inp_we  = idx_ok;
            OP_RD_HOLD, OP_RD_INPUT: begin
              sel_in_d = (opcode_i == OP_RD_INPUT);
              lok_d    = idx_ok;
              state_d  = ST_LREAD;
            end
            default: ;
          endcase
        end
      end
      ST_LREAD: begin
        word_d  = !lok_q ? 16'h0000 : (sel_in_q ? inp_rdata : hold_rdata);
        state_d = ST_LEMIT;
      end
      ST_LEMIT: begin
        emit            = 1'b1;
        item.kind       = KIND_LOCAL;
        item.read_value = word_q;
        item.event_res  = EV_NONE;
        item.last       = 1'b1;
        if (slot_free) state_d = ST_IDLE;
      end
      ST_DROP: begin
        emit           = 1'b1;
        item.kind      = KIND_DROP;
        item.event_res = code_q;
        item.last      = 1'b1;
        if (slot_free) state_d = ST_IDLE;
      end
      ST_CHK: begin
        crc_en   = 1'b1;
        crc_byte = frame_q[idx_q];
        idx_d    = idx_q + 3'd1;
        if (idx_q == 3'd5) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        crc_init = 1'b1;
        idx_d    = '0;
        if (crc != {frame_q[7], frame_q[6]}) begin
          code_d  = EV_BAD;
          state_d = ST_DROP;
        end else if (frame_q[1] == FN_WR_HOLD) begin
          if (17'(fb_addr) >= RC17) begin
            code_d  = EV_RANGE;
            state_d = ST_DROP;
          end else begin
            hold_we    = 1'b1;
            hold_waddr = fb_addr[AW-1:0];
            hold_wdata = fb_val;
            lw_addr_d  = fb_addr[6:0];
            lw_val_d   = fb_val;
            is_rd_d    = 1'b0;
            hdr_last_d = 3'd5;
            code_d     = EV_WRITE;
            state_d    = ST_TX_HDR;
          end
        end else begin
          if (fb_val == 16'h0000 || fb_val > MR16 || 17'(fb_addr) >= RC17 ||
              fb_end > RC17) begin
            code_d  = EV_RANGE;
            state_d = ST_DROP;
          end else begin
            ptr_d      = fb_addr[AW-1:0];
            cnt_d      = fb_val[CW-1:0];
            is_rd_d    = 1'b1;
            hdr_last_d = 3'd2;
            sel_in_d   = (frame_q[1] == FN_RD_INPUT);
            code_d     = (frame_q[1] == FN_RD_HOLD) ? EV_RD_HOLD : EV_RD_INPUT;
            state_d    = ST_TX_HDR;
          end
        end
      end
      ST_TX_HDR: begin
        emit           = 1'b1;
        item.kind      = KIND_TX;
        item.tx_byte   = hdr_byte;
        item.event_res = code_q;
        if (slot_free) begin
          crc_en   = 1'b1;
          crc_byte = hdr_byte;
          idx_d    = idx_q + 3'd1;
          if (idx_q == hdr_last_q) state_d = is_rd_q ? ST_RD_REQ : ST_CRCL;
        end
      end
      ST_RD_REQ: state_d = ST_RD_WAIT;
      ST_RD_WAIT: begin
        word_d  = sel_in_q ? inp_rdata : hold_rdata;
        state_d = ST_TX_HI;
      end
      ST_TX_HI: begin
        emit           = 1'b1;
        item.kind      = KIND_TX;
        item.tx_byte   = word_q[15:8];
        item.event_res = code_q;
        if (slot_free) begin
          crc_en   = 1'b1;
          crc_byte = word_q[15:8];
          state_d  = ST_TX_LO;
        end
      end
      ST_TX_LO: begin
        emit           = 1'b1;
        item.kind      = KIND_TX;
        item.tx_byte   = word_q[7:0];
        item.event_res = code_q;
        if (slot_free) begin
          crc_en   = 1'b1;
          crc_byte = word_q[7:0];
          ptr_d    = ptr_q + AW'(1);
          cnt_d    = cnt_q - CW'(1);
          state_d  = (cnt_q == CW'(1)) ? ST_CRCL : ST_RD_REQ;
        end
      end
      ST_CRCL: begin
        emit           = 1'b1;
        item.kind      = KIND_TX;
        item.tx_byte   = crc[7:0];
        item.event_res = code_q;
        if (slot_free) state_d = ST_CRCH;
      end
      ST_CRCH: begin
        emit           = 1'b1;
        item.kind      = KIND_TX;
        item.tx_byte   = crc[15:8];
        item.event_res = code_q;
        item.last      = 1'b1;
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      byte_cnt_q  <= '0;
      dev_id_q    <= DEV_ID_RESET;
      lw_addr_q   <= '0;
      lw_val_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      byte_cnt_q <= byte_cnt_d;
      lw_addr_q  <= lw_addr_d;
      lw_val_q   <= lw_val_d;
      if (cfg_valid_i && cfg_ready_o) dev_id_q <= cfg_data_i;
      if (emit && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    idx_q      <= idx_d;
    hdr_last_q <= hdr_last_d;
    is_rd_q    <= is_rd_d;
    sel_in_q   <= sel_in_d;
    lok_q      <= lok_d;
    ptr_q      <= ptr_d;
    cnt_q      <= cnt_d;
    word_q     <= word_d;
    if (frame_we) frame_q[byte_cnt_q[2:0]] <= data_i[7:0];
    if (emit && slot_free) out_q <= item;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign tx_byte_o       = out_q.tx_byte;
  assign read_value_o    = out_q.read_value;
  assign event_res_o     = out_q.event_res;
  assign written_addr_o  = out_q.written_addr;
  assign written_value_o = out_q.written_value;
  assign last_o          = out_q.last;

  `MRS_ASSERT_ALWAYS(a_clear_blocks_in, clk_i, (state_q == ST_CLEAR) |-> !in_ready_o)
  `MRS_ASSERT(a_last_ends_request, clk_i, rst_ni,
              (emit && slot_free && item.last) |=> (state_q == ST_IDLE))
  `MRS_ASSERT(a_read_count_live, clk_i, rst_ni,
              (state_q == ST_RD_REQ || state_q == ST_TX_LO) |-> (cnt_q != '0))
  `MRS_ASSERT(a_eof_clears_count, clk_i, rst_ni,
              (in_acc && opcode_i == OP_EOF) |=> (byte_cnt_q == 8'h00))

endmodule

@@ verif/mrs_checker.sv @@
// Scoreboard for the Modbus RTU slave engine: predicts results and compares them.
module mrs_checker #(
  parameter int REG_COUNT = 128,
  parameter int MAX_READ  = 29
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] data_i,
  input  logic [6:0]  reg_index_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_o,
  input  logic [7:0]  tx_byte_o,
  input  logic [15:0] read_value_o,
  input  logic [2:0]  event_res_o,
  input  logic [6:0]  written_addr_o,
  input  logic [15:0] written_value_o,
  input  logic        last_o,
  output int          fail_count_o,
  output int          pending_o
);
  import mrs_pkg::*;

  logic [7:0]  dev_id;
  logic [7:0]  frame_store [8];
  logic [7:0]  rx_count;
  logic [15:0] hold_mem [REG_COUNT];
  logic [15:0] input_mem [REG_COUNT];
  logic [6:0]  wr_addr;
  logic [15:0] wr_value;
  out_item_t   expected_q [$];
  int          mismatches;

  // one byte step of CRC-16, reflected form
  function automatic logic [15:0] crc_add(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic push_result(logic [1:0] kind, logic [7:0] txb, logic [15:0] rv,
                             logic [2:0] ev, logic fin);
    out_item_t it;
    it.kind          = kind;
    it.tx_byte       = txb;
    it.read_value    = rv;
    it.event_res     = ev;
    it.written_addr  = wr_addr;
    it.written_value = wr_value;
    it.last          = fin;
    expected_q.push_back(it);
  endtask

  task automatic push_reply(logic [7:0] msg [$], logic [2:0] ev);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (msg[i]) c = crc_add(c, msg[i]);
    msg.push_back(c[7:0]);
    msg.push_back(c[15:8]);
    foreach (msg[i]) push_result(KIND_TX, msg[i], '0, ev, i == msg.size() - 1);
  endtask

  task automatic close_frame();
    logic [7:0]  msg [$];
    logic [15:0] c, addr, cnt, w;
    logic        enough;
    enough   = rx_count >= 8;
    rx_count = 0;
    if (!enough) begin
      push_result(KIND_DROP, '0, '0, EV_SHORT, 1'b1);
      return;
    end
    if (frame_store[0] != dev_id && frame_store[0] != BROADCAST_ID) begin
      push_result(KIND_DROP, '0, '0, EV_FOREIGN, 1'b1);
      return;
    end
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc_add(c, frame_store[i]);
    if (!(frame_store[1] inside {FN_RD_HOLD, FN_RD_INPUT, FN_WR_HOLD}) ||
        c != {frame_store[7], frame_store[6]}) begin
      push_result(KIND_DROP, '0, '0, EV_BAD, 1'b1);
      return;
    end
    addr = {frame_store[2], frame_store[3]};
    cnt  = {frame_store[4], frame_store[5]};
    msg.push_back(frame_store[0]);
    msg.push_back(frame_store[1]);
    if (frame_store[1] == FN_WR_HOLD) begin
      if (addr >= REG_COUNT) begin
        push_result(KIND_DROP, '0, '0, EV_RANGE, 1'b1);
        return;
      end
      hold_mem[addr] = cnt;
      wr_addr        = addr[6:0];
      wr_value       = cnt;
      for (int i = 2; i < 6; i++) msg.push_back(frame_store[i]);
      push_reply(msg, EV_WRITE);
      return;
    end
    if (cnt == 0 || cnt > MAX_READ || addr >= REG_COUNT || addr + cnt > REG_COUNT) begin
      push_result(KIND_DROP, '0, '0, EV_RANGE, 1'b1);
      return;
    end
    msg.push_back(8'(cnt * 2));
    for (int i = 0; i < cnt; i++) begin
      w = (frame_store[1] == FN_RD_HOLD) ? hold_mem[addr + i] : input_mem[addr + i];
      msg.push_back(w[15:8]);
      msg.push_back(w[7:0]);
    end
    push_reply(msg, (frame_store[1] == FN_RD_HOLD) ? EV_RD_HOLD : EV_RD_INPUT);
  endtask

  task automatic take_request(logic [2:0] op, logic [15:0] d, logic [6:0] idx);
    case (op)
      OP_RX_BYTE: begin
        if (rx_count < 8) frame_store[rx_count] = d[7:0];
        if (rx_count < 255) rx_count++;
      end
      OP_EOF:      close_frame();
      OP_WR_HOLD:  if (idx < REG_COUNT) hold_mem[idx] = d;
      OP_WR_INPUT: if (idx < REG_COUNT) input_mem[idx] = d;
      OP_RD_HOLD:
        push_result(KIND_LOCAL, '0, (idx < REG_COUNT) ? hold_mem[idx] : '0, EV_NONE, 1'b1);
      OP_RD_INPUT:
        push_result(KIND_LOCAL, '0, (idx < REG_COUNT) ? input_mem[idx] : '0, EV_NONE, 1'b1);
      default: ;
    endcase
  endtask

  task automatic check_result();
    out_item_t got, want;
    got = '{kind_o, tx_byte_o, read_value_o, event_res_o, written_addr_o,
            written_value_o, last_o};
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = expected_q.pop_front();
    if (got.kind != want.kind || got.tx_byte != want.tx_byte ||
        got.read_value != want.read_value || got.event_res != want.event_res ||
        got.written_addr != want.written_addr ||
        got.written_value != want.written_value || got.last != want.last) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id   = DEV_ID_RESET;
      rx_count = 0;
      wr_addr  = 0;
      wr_value = 0;
      for (int i = 0; i < 8; i++) frame_store[i] = 0;
      for (int i = 0; i < REG_COUNT; i++) begin
        hold_mem[i]  = 0;
        input_mem[i] = 0;
      end
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) dev_id = cfg_data_i;
      if (in_valid_i && in_ready_o) take_request(opcode_i, data_i, reg_index_i);
      if (out_valid_o && out_ready_i) check_result();
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Stimulus and verdict for the Modbus RTU slave engine regression.
module tb_top;
  import mrs_pkg::*;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [2:0]  opcode_i;
  logic [15:0] data_i;
  logic [6:0]  reg_index_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [15:0] read_value_o;
  logic [2:0]  event_res_o;
  logic [6:0]  written_addr_o;
  logic [15:0] written_value_o;
  logic        last_o;
  int          fail_count, pending;

  logic [7:0]  own_id;     // device id as last written
  int          sent;       // requests accepted so far
  bit          no_gaps;    // burst stretch: sender never idles

  modbus_rtu_slave_engine i_dut (.*);

  mrs_checker i_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .data_i, .reg_index_i,
    .out_valid_o, .out_ready_i, .kind_o, .tx_byte_o, .read_value_o,
    .event_res_o, .written_addr_o, .written_value_o, .last_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // one byte step of CRC-16, reflected form
  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver side: stretches that are either always-ready or randomly stalled.
  initial begin
    int stall, stretch;
    bit calm;
    out_ready_i = 0;
    stall = 0;
    stretch = 0;
    calm = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stretch == 0) begin
        calm    = $urandom_range(0, 3) == 0;
        stretch = $urandom_range(50, 300);
      end
      stretch--;
      if (stall == 0 && !calm && $urandom_range(0, 2) == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // One request; valid is only dropped when a gap follows, so it never
  // sees two NBAs in one step.
  task automatic send_req(logic [2:0] op, logic [15:0] d, logic [6:0] idx);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_i      <= d;
    reg_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // A received byte; upper data bits are noise that the block ignores.
  task automatic send_byte(logic [7:0] b);
    send_req(OP_RX_BYTE, {8'($urandom), b}, 7'($urandom));
  endtask

  // Well-formed request frame with optional broken CRC and trailing bytes.
  task automatic send_frame(logic [7:0] id, logic [7:0] fn, logic [15:0] addr,
                            logic [15:0] val, bit bad_crc, int extra);
    logic [7:0]  b [8];
    logic [15:0] c;
    b = '{id, fn, addr[15:8], addr[7:0], val[15:8], val[7:0], 8'h00, 8'h00};
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc_step(c, b[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    b[6] = c[7:0];
    b[7] = c[15:8];
    foreach (b[i]) send_byte(b[i]);
    repeat (extra) send_byte(8'($urandom));
    send_req(OP_EOF, 16'($urandom), 7'($urandom));
  endtask

  task automatic send_junk(int n);
    repeat (n) send_byte(8'($urandom));
    send_req(OP_EOF, 16'($urandom), 7'($urandom));
  endtask

  // Config writes only once the block has drained.
  task automatic write_id(logic [7:0] id);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (30) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    own_id = id;
  endtask

  // Random frame traffic: mostly sound frames, some noise and broken ones.
  task automatic random_frame();
    logic [7:0]  id, fn;
    logic [15:0] addr, cnt;
    int r;
    r  = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) < 7) ? own_id :
         ($urandom_range(0, 1) ? BROADCAST_ID : 8'($urandom));
    case ($urandom_range(0, 9))
      0, 1, 2: fn = FN_RD_HOLD;
      3, 4:    fn = FN_RD_INPUT;
      5, 6, 7, 8: fn = FN_WR_HOLD;
      default: fn = 8'($urandom);
    endcase
    if (fn == FN_WR_HOLD) begin
      addr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 127));
      cnt  = 16'($urandom);
    end else begin
      cnt  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40)) :
             16'($urandom_range(1, 4));
      addr = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
             16'($urandom_range(0, 127 - 4));
    end
    if (r < 8) send_junk($urandom_range(0, 7));
    else send_frame(id, fn, addr, cnt, r < 16, (r < 22) ? $urandom_range(1, 5) : 0);
  endtask

  initial begin
    int rd_count;
    rst_ni      = 0;
    cfg_valid_i = 0;
    cfg_data_i  = 0;
    in_valid_i  = 0;
    opcode_i    = 0;
    data_i      = 0;
    reg_index_i = 0;
    own_id      = DEV_ID_RESET;
    sent        = 0;
    no_gaps     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: register extremes, every opcode, every frame outcome but a good input read.
    send_req(OP_WR_HOLD, 16'hFFFF, 7'd127);
    send_req(OP_WR_INPUT, 16'hFFFF, 7'd0);
    send_req(OP_RD_HOLD, 16'h0000, 7'd127);
    send_req(OP_RD_INPUT, 16'hFFFF, 7'd0);
    send_req(3'd6, 16'hFFFF, 7'd1);                              // unused opcodes
    send_req(3'd7, 16'h0000, 7'd2);
    send_req(OP_EOF, 16'h0, 7'd0);                               // empty frame
    send_junk(7);                                                // short
    send_frame(8'd5, FN_RD_HOLD, 16'd0, 16'd1, 0, 0);           // foreign id
    send_frame(own_id, 8'd16, 16'd0, 16'd1, 0, 0);              // unknown function
    send_frame(own_id, FN_WR_HOLD, 16'd1, 16'h1234, 1, 0);      // CRC mismatch
    send_frame(own_id, FN_WR_HOLD, 16'd127, 16'hFFFF, 0, 0);    // top register
    send_frame(BROADCAST_ID, FN_WR_HOLD, 16'd0, 16'h0000, 0, 0);
    send_frame(own_id, FN_WR_HOLD, 16'd128, 16'h5555, 0, 0);    // write out of range
    send_frame(own_id, FN_RD_HOLD, 16'd99, 16'd29, 0, 0);       // longest read
    send_frame(own_id, FN_RD_HOLD, 16'd100, 16'd29, 0, 0);      // runs past the end
    send_frame(own_id, FN_RD_HOLD, 16'd0, 16'd0, 0, 0);         // zero count
    send_frame(own_id, FN_RD_INPUT, 16'd0, 16'd30, 0, 0);       // count too big
    send_frame(own_id, FN_WR_HOLD, 16'd3, 16'hABCD, 0, 249);    // count saturates

    // Random phases over several device ids, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_id(8'd1);
        1: write_id(BROADCAST_ID);
        2: write_id(8'($urandom_range(2, 246)));
        default: write_id(DEV_ID_RESET);
      endcase
      rd_count = sent + 4;
      while (sent < rd_count) begin
        no_gaps = $urandom_range(0, 4) == 0;
        case ($urandom_range(0, 9))
          0: send_req(OP_WR_HOLD, 16'($urandom), 7'($urandom));
          1: send_req(OP_WR_INPUT, 16'($urandom), 7'($urandom));
          2: send_req($urandom_range(0, 1) ? OP_RD_HOLD : OP_RD_INPUT,
                      16'($urandom), 7'($urandom));
          3: send_req(3'($urandom_range(6, 7)), 16'($urandom), 7'($urandom));
          default: random_frame();
        endcase
      end
    end
    no_gaps = 0;
    in_valid_i <= 1'b0;

    // Drain, then let any stray result show up.
    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
